[rtl/jetp_pkg.sv]
// shared types and constants of the julia escape-time pixel block
package jetp_pkg;

  localparam int PIX_W      = 10;
  localparam int ITER_W     = 3;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int C_W        = 14;
  localparam int STEP_W     = 15;
  localparam int CENTER_W   = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_REAL     = 3'd0,
    REG_C_IMAG     = 3'd1,
    REG_STEP_H     = 3'd2,
    REG_STEP_V     = 3'd3,
    REG_CENTER_COL = 3'd4,
    REG_CENTER_ROW = 3'd5
  } cfg_reg_t;

  localparam logic signed [C_W-1:0]    C_REAL_RST     = 14'sd3230;
  localparam logic signed [C_W-1:0]    C_IMAG_RST     = 14'sd0;
  localparam logic [STEP_W-1:0]        STEP_H_RST     = 15'd154;
  localparam logic [STEP_W-1:0]        STEP_V_RST     = 15'd1024;
  localparam logic [CENTER_W-1:0]      CENTER_COL_RST = 10'd40;
  localparam logic [CENTER_W-1:0]      CENTER_ROW_RST = 10'd12;

endpackage

[rtl/jetp_in_if.sv]
// pixel coordinate channel and result channel interfaces
interface jetp_in_if;
  import jetp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_col;
  logic [PIX_W-1:0] pix_row;

  modport source (output valid, output pix_col, output pix_row, input ready);
  modport sink   (input valid, input pix_col, input pix_row, output ready);
endinterface

interface jetp_out_if;
  import jetp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iter_count;
  logic              blank;

  modport source (output valid, output iter_count, output blank, input ready);
  modport sink   (input valid, input iter_count, input blank, output ready);
endinterface

[rtl/julia_escape_time_pixel.sv]
// julia escape-time evaluator, one pixel per transfer, fully pipelined
// Usage:
//   in_chan carries pix_col and pix_row; out_chan returns iter_count and blank,
//   one result per input transfer, in input order.
//   cfg_we/cfg_idx/cfg_data write c_real, c_imag, step_horizontal,
//   step_vertical, center_col and center_row (indexes 0 to 5); other
//   indexes are ignored. Write only while no pixel is in flight.
// Pipeline: one mapping stage, two stages per iteration (square products,
//   then escape test and update) and the output register.
// Throughput: one pixel per clock while out_chan.ready stays high; every iteration has its own multipliers.
// Reset: rst_n low clears all stage valid bits and loads the register
//   defaults; the pipeline is empty afterwards.
// Stall: each stage holds while its successor is full and blocked, so
//   empty stages keep filling while out_chan.ready is low; in_chan.ready
//   drops only once every stage holds a pixel.
module julia_escape_time_pixel #(
  parameter int MAX_ITER    = 7,
  parameter int COORD_RANGE = 1024,
  parameter int FRAC_BITS   = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jetp_in_if.sink                         in_chan,
  jetp_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [jetp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jetp_pkg::*;

  localparam int ZW  = FRAC_BITS + 4;
  localparam int PW  = 2 * ZW;
  localparam int PW1 = PW + 1;
  localparam int MW  = 27;
  localparam int SW  = (PW + 2 > MW) ? PW + 2 : MW;
  localparam int NW  = $clog2(MAX_ITER + 1);

  localparam logic signed [SW-1:0] ZHI   = SW'((64'sd1 <<< (ZW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] ZLO   = SW'(-(64'sd1 <<< (ZW - 1)));
  localparam logic [PW:0]          LIMIT = PW1'(1) << (2 * FRAC_BITS + 2);
  localparam logic [12:0]          CR_MAX = 13'(COORD_RANGE - 1);

  function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] s;
    s = (v > ZHI) ? ZHI : ((v < ZLO) ? ZLO : v);
    return $signed(s[ZW-1:0]);
  endfunction

  // configuration registers
  logic signed [C_W-1:0]   c_real_r, c_imag_r;
  logic [STEP_W-1:0]       step_h_r, step_v_r;
  logic [CENTER_W-1:0]     center_col_r, center_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r     <= C_REAL_RST;
      c_imag_r     <= C_IMAG_RST;
      step_h_r     <= STEP_H_RST;
      step_v_r     <= STEP_V_RST;
      center_col_r <= CENTER_COL_RST;
      center_row_r <= CENTER_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_C_REAL:     c_real_r     <= $signed(cfg_data[C_W-1:0]);
        REG_C_IMAG:     c_imag_r     <= $signed(cfg_data[C_W-1:0]);
        REG_STEP_H:     step_h_r     <= cfg_data[STEP_W-1:0];
        REG_STEP_V:     step_v_r     <= cfg_data[STEP_W-1:0];
        REG_CENTER_COL: center_col_r <= cfg_data[CENTER_W-1:0];
        REG_CENTER_ROW: center_row_r <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline storage: z stage k feeds product stage k
  logic                 zv_r    [0:MAX_ITER];
  logic signed [ZW-1:0] zr_r    [0:MAX_ITER];
  logic signed [ZW-1:0] zi_r    [0:MAX_ITER];
  logic [NW-1:0]        zn_r    [0:MAX_ITER];
  logic                 zdone_r [0:MAX_ITER];
  logic                 z_en    [0:MAX_ITER];

  logic                 pv_r    [0:MAX_ITER-1];
  logic signed [PW-1:0] rr_r    [0:MAX_ITER-1];
  logic signed [PW-1:0] ii_r    [0:MAX_ITER-1];
  logic signed [PW-1:0] ri_r    [0:MAX_ITER-1];
  logic [NW-1:0]        pn_r    [0:MAX_ITER-1];
  logic                 pdone_r [0:MAX_ITER-1];
  logic                 p_en    [0:MAX_ITER-1];

  logic                 out_valid_r;
  logic [ITER_W-1:0]    iter_r;
  logic                 blank_r;
  logic                 out_en;

  assign out_en        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = z_en[0];

  // mapping stage
  logic [PIX_W-1:0]     col_cl, row_cl;
  logic signed [10:0]   dcol, drow;
  logic signed [MW-1:0] pcol, prow;
  logic signed [ZW-1:0] zr0_nxt, zi0_nxt;

  always_comb begin
    col_cl  = ({3'b000, in_chan.pix_col} > CR_MAX) ? CR_MAX[PIX_W-1:0] : in_chan.pix_col;
    row_cl  = ({3'b000, in_chan.pix_row} > CR_MAX) ? CR_MAX[PIX_W-1:0] : in_chan.pix_row;
    dcol    = $signed({1'b0, col_cl}) - $signed({1'b0, center_col_r});
    drow    = $signed({1'b0, row_cl}) - $signed({1'b0, center_row_r});
    pcol    = dcol * $signed({1'b0, step_h_r});
    prow    = drow * $signed({1'b0, step_v_r});
    zr0_nxt = sat_z(SW'(pcol));
    zi0_nxt = sat_z(SW'(prow));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zv_r[0] <= 1'b0;
    end else if (z_en[0]) begin
      zv_r[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (z_en[0]) begin
      zr_r[0]    <= zr0_nxt;
      zi_r[0]    <= zi0_nxt;
      zn_r[0]    <= '0;
      zdone_r[0] <= 1'b0;
    end
  end

  // iteration stages
  for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
    logic [PW:0]          mag_sq;
    logic                 escape;
    logic signed [SW-1:0] re_full, im_full;
    logic signed [ZW-1:0] zr_nxt, zi_nxt;
    logic [NW-1:0]        n_nxt;
    logic                 done_nxt;

    assign z_en[k] = !zv_r[k] || p_en[k];
    assign p_en[k] = !pv_r[k] || z_en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k] <= 1'b0;
      end else if (p_en[k]) begin
        pv_r[k] <= zv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (p_en[k]) begin
        rr_r[k]    <= zr_r[k] * zr_r[k];
        ii_r[k]    <= zi_r[k] * zi_r[k];
        ri_r[k]    <= zr_r[k] * zi_r[k];
        pn_r[k]    <= zn_r[k];
        pdone_r[k] <= zdone_r[k];
      end
    end

    always_comb begin
      mag_sq  = PW1'(unsigned'(rr_r[k])) + PW1'(unsigned'(ii_r[k]));
      escape  = mag_sq >= LIMIT;
      re_full = ((SW'(rr_r[k]) - SW'(ii_r[k])) >>> FRAC_BITS) + SW'(c_real_r);
      im_full = ((SW'(ri_r[k]) <<< 1) >>> FRAC_BITS) + SW'(c_imag_r);
      zr_nxt   = sat_z(re_full);
      zi_nxt   = sat_z(im_full);
      done_nxt = pdone_r[k] || escape;
      n_nxt    = done_nxt ? pn_r[k] : NW'(pn_r[k] + 1'b1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        zv_r[k+1] <= 1'b0;
      end else if (z_en[k+1]) begin
        zv_r[k+1] <= pv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (z_en[k+1]) begin
        zr_r[k+1]    <= zr_nxt;
        zi_r[k+1]    <= zi_nxt;
        zn_r[k+1]    <= n_nxt;
        zdone_r[k+1] <= done_nxt;
      end
    end
  end

  assign z_en[MAX_ITER] = !zv_r[MAX_ITER] || out_en;

  // output register
  logic [3:0]        n_final;
  logic [ITER_W-1:0] iter_nxt;
  logic              blank_nxt;

  always_comb begin
    n_final   = 4'(zn_r[MAX_ITER]);
    iter_nxt  = (n_final > 4'd7) ? 3'd7 : n_final[ITER_W-1:0];
    blank_nxt = n_final < 4'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= zv_r[MAX_ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      iter_r  <= iter_nxt;
      blank_r <= blank_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.iter_count = iter_r;
  assign out_chan.blank      = blank_r;

endmodule

[rtl/jetp_chk.sv]
// port-level checks for the julia escape-time pixel block and their bind
module jetp_chk #(
  parameter int MAX_ITER = 7
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jetp_pkg::ITER_W-1:0] out_iter,
  input logic                        out_blank
);
  import jetp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iter) && $stable(out_blank))
    else $error("stalled result changed");

  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blank == (out_iter < 3'd2)))
    else $error("blank flag disagrees with count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (MAX_ITER >= 7) || (int'(out_iter) <= MAX_ITER))
    else $error("count above iteration limit");

endmodule

bind julia_escape_time_pixel jetp_chk #(.MAX_ITER(MAX_ITER)) u_jetp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_iter  (out_chan.iter_count),
  .out_blank (out_chan.blank)
);

[test/jetp_checker.sv]
// checker for the julia escape-time pixel block: escape-time predictor and result comparison
module jetp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  jetp_in_if                              in_chan,
  jetp_out_if                             out_chan,
  input  logic                            cfg_we,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [jetp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import jetp_pkg::*;

  localparam int     MAX_ITER    = 7;
  localparam int     COORD_RANGE = 1024;
  localparam int     FRAC_BITS   = 12;
  localparam int     ITER_MAX    = (1 << ITER_W) - 1;
  localparam longint Z_MAX       = (longint'(1) << (FRAC_BITS + 3)) - 1;
  localparam longint Z_MIN       = -(longint'(1) << (FRAC_BITS + 3));
  localparam longint ESCAPE_SQ   = longint'(4) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              blank;
  } pixel_result_t;

  logic signed [C_W-1:0] c_re_q;
  logic signed [C_W-1:0] c_im_q;
  logic [STEP_W-1:0]     step_h_q;
  logic [STEP_W-1:0]     step_v_q;
  logic [CENTER_W-1:0]   ctr_col_q;
  logic [CENTER_W-1:0]   ctr_row_q;

  pixel_result_t expected_q[$];

  function automatic longint clip_q(longint v);
    if (v > Z_MAX) return Z_MAX;
    if (v < Z_MIN) return Z_MIN;
    return v;
  endfunction

  function automatic pixel_result_t escape_time(logic [PIX_W-1:0] col_in,
                                                logic [PIX_W-1:0] row_in);
    longint        col;
    longint        row;
    longint        cre;
    longint        cim;
    longint        zr;
    longint        zi;
    longint        nr;
    longint        ni;
    int            n;
    pixel_result_t r;
    col = (longint'(col_in) >= COORD_RANGE) ? COORD_RANGE - 1 : longint'(col_in);
    row = (longint'(row_in) >= COORD_RANGE) ? COORD_RANGE - 1 : longint'(row_in);
    cre = c_re_q;
    cim = c_im_q;
    zr  = clip_q((col - longint'(ctr_col_q)) * longint'(step_h_q));
    zi  = clip_q((row - longint'(ctr_row_q)) * longint'(step_v_q));
    n   = 0;
    while (n < MAX_ITER && zr * zr + zi * zi < ESCAPE_SQ) begin
      nr = clip_q(((zr * zr - zi * zi) >>> FRAC_BITS) + cre);
      ni = clip_q(((2 * zr * zi) >>> FRAC_BITS) + cim);
      zr = nr;
      zi = ni;
      n++;
    end
    r.iter_count = (n > ITER_MAX) ? ITER_W'(ITER_MAX) : ITER_W'(n);
    r.blank      = (n < 2);
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      c_re_q    = C_REAL_RST;
      c_im_q    = C_IMAG_RST;
      step_h_q  = STEP_H_RST;
      step_v_q  = STEP_V_RST;
      ctr_col_q = CENTER_COL_RST;
      ctr_row_q = CENTER_ROW_RST;
      expected_q.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_q.size() == 0) begin
          $error("iter_count: expected no transfer, got %0d", out_chan.iter_count);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_chan.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, got %0d", want.iter_count,
                   out_chan.iter_count);
            mismatches++;
          end
          if (out_chan.blank !== want.blank) begin
            $error("blank: expected %0d, got %0d", want.blank, out_chan.blank);
            mismatches++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready)
        expected_q.push_back(escape_time(in_chan.pix_col, in_chan.pix_row));
      if (cfg_we) begin
        case (cfg_idx)
          REG_C_REAL:     c_re_q    = cfg_data[C_W-1:0];
          REG_C_IMAG:     c_im_q    = cfg_data[C_W-1:0];
          REG_STEP_H:     step_h_q  = cfg_data[STEP_W-1:0];
          REG_STEP_V:     step_v_q  = cfg_data[STEP_W-1:0];
          REG_CENTER_COL: ctr_col_q = cfg_data[CENTER_W-1:0];
          REG_CENTER_ROW: ctr_row_q = cfg_data[CENTER_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

[test/tb.sv]
// testbench top: clock, reset, pixel and register stimulus, and the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jetp_pkg::*;

  localparam int LATENCY = 15;
  localparam int PHASES  = 6;
  localparam int PHASE_N = 100;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
    logic [STEP_W-1:0]     step_h;
    logic [STEP_W-1:0]     step_v;
    logic [CENTER_W-1:0]   ctr_col;
    logic [CENTER_W-1:0]   ctr_row;
  } view_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  bit                    gaps_on;

  jetp_in_if  in_chan();
  jetp_out_if out_chan();

  julia_escape_time_pixel u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  jetp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin
    out_chan.ready <= !(gaps_on && $urandom_range(0, 99) < 10);
  end

  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.pix_col <= col;
    in_chan.pix_row <= row;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic program_view(input view_t v);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_C_REAL;
    cfg_data <= CFG_DATA_W'(v.c_re);
    @(negedge clk);
    cfg_idx  <= REG_C_IMAG;
    cfg_data <= CFG_DATA_W'(v.c_im);
    @(negedge clk);
    cfg_idx  <= REG_STEP_H;
    cfg_data <= v.step_h;
    @(negedge clk);
    cfg_idx  <= REG_STEP_V;
    cfg_data <= v.step_v;
    @(negedge clk);
    cfg_idx  <= REG_CENTER_COL;
    cfg_data <= CFG_DATA_W'(v.ctr_col);
    @(negedge clk);
    cfg_idx  <= REG_CENTER_ROW;
    cfg_data <= CFG_DATA_W'(v.ctr_row);
    @(negedge clk);
    // unused indexes must leave the view untouched
    cfg_idx  <= ($urandom_range(0, 1) != 0) ? IDX_SPARE_LO : IDX_SPARE_HI;
    cfg_data <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] near(input int centre, input int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > (1 << PIX_W) - 1) v = (1 << PIX_W) - 1;
    return PIX_W'(v);
  endfunction

  initial begin
    view_t v;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.pix_col = '0;
    in_chan.pix_row = '0;
    out_chan.ready  = 1'b0;
    gaps_on         = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset view
    send_pixel(10'd40, 10'd12);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    send_pixel(10'd41, 10'd12);
    send_pixel(10'd45, 10'd13);
    drain();

    // c at zero: centre never escapes, |z|^2 exactly 4 escapes at once
    program_view('{c_re: 0, c_im: 0, step_h: 154, step_v: 1024, ctr_col: 40, ctr_row: 12});
    send_pixel(10'd40, 10'd12);
    send_pixel(10'd80, 10'd12);
    send_pixel(10'd70, 10'd12);
    send_pixel(10'd60, 10'd12);
    send_pixel(10'd40, 10'd19);
    send_pixel(10'd40, 10'd20);
    drain();

    program_view('{c_re: -4096, c_im: 4096, step_h: 32767, step_v: 0, ctr_col: 0,
                   ctr_row: 512});
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1023);
    send_pixel(10'd1023, 10'd512);
    drain();

    program_view('{c_re: 4096, c_im: -4096, step_h: 0, step_v: 32767, ctr_col: 512,
                   ctr_row: 0});
    send_pixel(10'd512, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd1);
    drain();

    program_view('{c_re: 8191, c_im: -8192, step_h: 1, step_v: 1, ctr_col: 1023,
                   ctr_row: 1023});
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      v.c_re    = C_W'(int'($urandom_range(0, 6460)) - 3230);
      v.c_im    = C_W'(int'($urandom_range(0, 6460)) - 3230);
      v.step_h  = STEP_W'($urandom_range(20, 400));
      v.step_v  = STEP_W'($urandom_range(40, 1600));
      v.ctr_col = CENTER_W'($urandom_range(0, 512));
      v.ctr_row = CENTER_W'($urandom_range(0, 512));
      program_view(v);
      gaps_on = (p != 2);
      for (int i = 0; i < PHASE_N; i++) begin
        if (p == 3 && i == PHASE_N / 2) drain();
        if ($urandom_range(0, 99) < 80)
          send_pixel(near(v.ctr_col, 60), near(v.ctr_row, 25));
        else
          send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      end
      drain();
    end
    gaps_on = 1'b1;

    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[julia_escape_time_pixel.f]
rtl/jetp_pkg.sv
rtl/jetp_in_if.sv
rtl/julia_escape_time_pixel.sv
rtl/jetp_chk.sv
test/jetp_checker.sv
test/tb.sv
